### hw/rtl/dvfs_pkg.sv
`timescale 1ns / 1ps

package dvfs_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int CLASS_LIMIT = 2;

   localparam logic [1:0] CLASS_ONCE  = 2'd0;
   localparam logic [1:0] CLASS_TWICE = 2'd1;
   localparam logic [1:0] CLASS_MANY  = 2'd2;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last_item;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] distinct_value;
      logic [5:0]                    frequency;
      logic [1:0]                    frequency_class;
      logic [4:0]                    first_position;
      logic signed [VALUE_WIDTH-1:0] most_value;
      logic [5:0]                    most_count;
      logic signed [VALUE_WIDTH-1:0] least_value;
      logic [5:0]                    least_count;
      logic [5:0]                    distinct_total;
      logic                          overflow;
      logic                          last_result;
   } rsp_type;

endpackage

### hw/rtl/distinct_value_frequency_sort_unit.sv
`timescale 1ns / 1ps

// Counts the distinct values of a set (one value per item, last item marked)
// and, on the marked item, emits one result per distinct value in ascending
// signed order, each carrying its frequency, class, first position and the
// set-wide most/least repeated values (ties to the earliest seen). All
// table work runs through one RAM with a single read port: an unmarked
// item reads and compares table entries in turn until it finds its value
// or reaches the end, and the marked item adds one full table scan, read
// and compare per entry, before each result. req_ready is high only while
// idle: it stays low while an item's table search, and for a marked item
// each of its results up to the last, is pending. Items beyond DEPTH are
// dropped and flag overflow on the results of that set.
module distinct_value_frequency_sort_unit #(
   parameter int DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dvfs_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dvfs_pkg::rsp_type rsp_item
);

   import dvfs_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = IW;
   localparam int WW = VALUE_WIDTH + CW + PW;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RD       = 3'd1;
   localparam logic [2:0] ST_CMP      = 3'd2;
   localparam logic [2:0] ST_SCAN_RD  = 3'd3;
   localparam logic [2:0] ST_SCAN_CMP = 3'd4;
   localparam logic [2:0] ST_EMIT     = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] used_ff, used_in, taken_ff, taken_in, emitted_ff, emitted_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic ovf_ff, ovf_in, last_ff, last_in, have_best_ff, have_best_in;
   logic signed [VALUE_WIDTH-1:0] val_ff, val_in, prev_ff, prev_in;
   logic signed [VALUE_WIDTH-1:0] best_val_ff, best_val_in;
   logic [CW-1:0] best_cnt_ff, best_cnt_in;
   logic [PW-1:0] best_pos_ff, best_pos_in;
   logic signed [VALUE_WIDTH-1:0] most_val_ff, most_val_in, least_val_ff, least_val_in;
   logic [CW-1:0] most_cnt_ff, most_cnt_in, least_cnt_ff, least_cnt_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [WW-1:0] wr_data, rd_data;
   logic signed [VALUE_WIDTH-1:0] rd_val;
   logic [CW-1:0] rd_cnt;
   logic [PW-1:0] rd_pos;
   logic [CW-1:0] idx_next;
   logic          more;
   logic          cand;

   dvfs_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_val   = rd_data[WW-1 -: VALUE_WIDTH];
   assign rd_cnt   = rd_data[PW +: CW];
   assign rd_pos   = rd_data[PW-1:0];
   assign idx_next = CW'(idx_ff) + CW'(1);
   assign more     = idx_next < used_ff;
   assign cand     = ((emitted_ff == '0) || (rd_val > prev_ff))
                     && (!have_best_ff || (rd_val < best_val_ff));
   assign rd_addr  = idx_ff;

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      taken_in     = taken_ff;
      emitted_in   = emitted_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      have_best_in = have_best_ff;
      val_in       = val_ff;
      prev_in      = prev_ff;
      best_val_in  = best_val_ff;
      best_cnt_in  = best_cnt_ff;
      best_pos_in  = best_pos_ff;
      most_val_in  = most_val_ff;
      most_cnt_in  = most_cnt_ff;
      least_val_in = least_val_ff;
      least_cnt_in = least_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = used_ff[IW-1:0];
      wr_data      = {val_ff, CW'(1), taken_ff[PW-1:0]};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in  = req_item.value;
               last_in = req_item.last_item;
               idx_in  = '0;
               if (taken_ff >= CW'(DEPTH)) begin
                  ovf_in   = 1'b1;
                  state_in = ST_SCAN_RD;
                  if (!req_item.last_item) begin
                     state_in = ST_IDLE;
                  end else if (used_ff == '0) begin
                     state_in = ST_IDLE;
                     used_in  = '0;
                     taken_in = '0;
                     ovf_in   = 1'b0;
                  end
                  emitted_in   = '0;
                  have_best_in = 1'b0;
               end else if (used_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = {req_item.value, CW'(1), taken_ff[PW-1:0]};
                  used_in  = CW'(1);
                  taken_in = taken_ff + CW'(1);
                  state_in = req_item.last_item ? ST_SCAN_RD : ST_IDLE;
                  emitted_in   = '0;
                  have_best_in = 1'b0;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rd_val == val_ff) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_data  = {rd_val, rd_cnt + CW'(1), rd_pos};
               taken_in = taken_ff + CW'(1);
               state_in = last_ff ? ST_SCAN_RD : ST_IDLE;
               idx_in   = '0;
            end else if (more) begin
               idx_in   = idx_next[IW-1:0];
               state_in = ST_RD;
            end else begin
               wr_en    = 1'b1;
               used_in  = used_ff + CW'(1);
               taken_in = taken_ff + CW'(1);
               state_in = last_ff ? ST_SCAN_RD : ST_IDLE;
               idx_in   = '0;
            end
            emitted_in   = '0;
            have_best_in = 1'b0;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (cand) begin
               have_best_in = 1'b1;
               best_val_in  = rd_val;
               best_cnt_in  = rd_cnt;
               best_pos_in  = rd_pos;
            end
            if (emitted_ff == '0) begin
               if ((idx_ff == '0) || (rd_cnt > most_cnt_ff)) begin
                  most_val_in = rd_val;
                  most_cnt_in = rd_cnt;
               end
               if ((idx_ff == '0) || (rd_cnt < least_cnt_ff)) begin
                  least_val_in = rd_val;
                  least_cnt_in = rd_cnt;
               end
            end
            if (more) begin
               idx_in   = idx_next[IW-1:0];
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               emitted_in   = emitted_ff + CW'(1);
               prev_in      = best_val_ff;
               idx_in       = '0;
               have_best_in = 1'b0;
               if (emitted_ff + CW'(1) == used_ff) begin
                  state_in = ST_IDLE;
                  used_in  = '0;
                  taken_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         taken_ff     <= '0;
         ovf_ff       <= 1'b0;
         emitted_ff   <= '0;
         have_best_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         taken_ff     <= taken_in;
         ovf_ff       <= ovf_in;
         emitted_ff   <= emitted_in;
         have_best_ff <= have_best_in;
      end
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      val_ff       <= val_in;
      prev_ff      <= prev_in;
      best_val_ff  <= best_val_in;
      best_cnt_ff  <= best_cnt_in;
      best_pos_ff  <= best_pos_in;
      most_val_ff  <= most_val_in;
      most_cnt_ff  <= most_cnt_in;
      least_val_ff <= least_val_in;
      least_cnt_ff <= least_cnt_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      rsp_item.distinct_value = best_val_ff;
      rsp_item.frequency      = 6'(best_cnt_ff);
      if (best_cnt_ff > CW'(CLASS_LIMIT)) begin
         rsp_item.frequency_class = CLASS_MANY;
      end else if (best_cnt_ff == CW'(CLASS_LIMIT)) begin
         rsp_item.frequency_class = CLASS_TWICE;
      end else begin
         rsp_item.frequency_class = CLASS_ONCE;
      end
      rsp_item.first_position = 5'(best_pos_ff);
      rsp_item.most_value     = most_val_ff;
      rsp_item.most_count     = 6'(most_cnt_ff);
      rsp_item.least_value    = least_val_ff;
      rsp_item.least_count    = 6'(least_cnt_ff);
      rsp_item.distinct_total = 6'(used_ff);
      rsp_item.overflow       = ovf_ff;
      rsp_item.last_result    = (emitted_ff + CW'(1) == used_ff);
   end

endmodule

### hw/rtl/dvfs_ram.sv
`timescale 1ns / 1ps

module dvfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hw/rtl/dvfs_checker.sv
`timescale 1ns / 1ps

module dvfs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input dvfs_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dvfs_pkg::rsp_type rsp_item
);

   import dvfs_pkg::*;

   // a waiting item holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_item))
      else $error("waiting item changed");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // no new item while results drain
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("ready while emitting");

   // more results follow a non-final one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.last_result |=> !req_ready)
      else $error("run ended early");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.frequency_class == CLASS_ONCE)
                     == (rsp_item.frequency == 6'd1)))
      else $error("class mismatch");

endmodule

bind distinct_value_frequency_sort_unit dvfs_checker u_dvfs_checker (.*);
